[hdl/mflc_pkg.sv]
// Shared types and constants for the mailbox flag and light controller.
`default_nettype none

package mflc_pkg;

  // Event kinds carried by an input item.
  typedef enum logic [1:0] {
    KindDoor = 2'd0,
    KindBeam = 2'd1,
    KindTick = 2'd2
  } kind_e;

  // Configuration register map.
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFlagUp     = 4'd0,
    CfgFlagDown   = 4'd1,
    CfgFlagHold   = 4'd2,
    CfgLightRamp  = 4'd3
  } cfg_idx_e;

  // Register reset values.
  localparam logic [15:0] FlagUpReset    = 16'd670;
  localparam logic [15:0] FlagDownReset  = 16'd1350;
  localparam logic [7:0]  FlagHoldReset  = 8'd150;
  localparam logic [7:0]  LightRampReset = 8'd150;

  localparam logic [7:0] FullDuty = 8'd255;

  // Ramp duty is count^2 / 88. Split 88 into 8 * 11: shift by three, then
  // multiply by a reciprocal of 11 that is exact for inputs below 2^15.
  localparam int SqW          = 16;
  localparam int RampDivisor  = 88;
  localparam int RampPow2Sh   = 3;
  localparam int RampOdd      = RampDivisor >> RampPow2Sh;
  localparam int RecipShift   = 15;
  localparam int RecipMul     = ((1 << RecipShift) + RampOdd - 1) / RampOdd;
  localparam int RecipW       = $clog2(RecipMul + 1);
  localparam int RampXW       = SqW - RampPow2Sh;
  localparam int RampProdW    = RampXW + RecipW;
  localparam int RampQW       = RampProdW - RecipShift;

  typedef struct packed {
    logic [15:0] flag_up;
    logic [15:0] flag_down;
    logic [7:0]  flag_hold;
    logic [7:0]  light_ramp;
  } cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       level;
  } item_t;

endpackage

`default_nettype wire

[hdl/mflc_cfg.sv]
// Configuration register file for the mailbox flag and light controller.
`default_nettype none

module mflc_cfg (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire [mflc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire [mflc_pkg::CfgDataW-1:0]  cfg_data_i,
  output mflc_pkg::cfg_t                cfg_o
);

  mflc_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;

  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i & cfg_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (cfg_index_i)
        mflc_pkg::CfgFlagUp:    cfg_d.flag_up    = cfg_data_i;
        mflc_pkg::CfgFlagDown:  cfg_d.flag_down  = cfg_data_i;
        mflc_pkg::CfgFlagHold:  cfg_d.flag_hold  = cfg_data_i[7:0];
        mflc_pkg::CfgLightRamp: cfg_d.light_ramp = cfg_data_i[7:0];
        default: ;  // drop writes outside the map
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flag_up    <= mflc_pkg::FlagUpReset;
      cfg_q.flag_down  <= mflc_pkg::FlagDownReset;
      cfg_q.flag_hold  <= mflc_pkg::FlagHoldReset;
      cfg_q.light_ramp <= mflc_pkg::LightRampReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[hdl/mflc_in_reg.sv]
// Input register stage: captures one event item and holds it until taken.
`default_nettype none

module mflc_in_reg (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire [1:0]          kind_i,
  input  wire                level_i,
  input  wire                take_i,
  output logic               item_valid_o,
  output mflc_pkg::item_t    item_o
);

  logic            valid_q, valid_d;
  mflc_pkg::item_t item_q, item_d;
  logic            load;

  // Refill whenever the stage is empty or its item leaves this cycle.
  assign in_stall_o = valid_q & ~take_i;
  assign load       = in_valid_i & ~in_stall_o;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (load) begin
      valid_d      = 1'b1;
      item_d.kind  = kind_i;
      item_d.level = level_i;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

[hdl/mflc_core.sv]
// Event update logic and result register of the mailbox controller.
`default_nettype none

module mflc_core (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  mflc_pkg::cfg_t    cfg_i,
  input  wire               item_valid_i,
  input  mflc_pkg::item_t   item_i,
  output logic              take_o,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output logic [15:0]       servo_compare_o,
  output logic [7:0]        light_duty_o,
  output logic              light_drive_enable_o,
  output logic              door_indicator_o,
  output logic              beam_indicator_o,
  output logic              flag_is_up_o,
  output logic              door_is_open_o
);

  typedef enum logic [1:0] {
    PhOff  = 2'd0,
    PhOn   = 2'd1,
    PhRamp = 2'd2
  } phase_e;

  logic                 out_valid_q, out_valid_d;
  logic                 door_q, door_d;
  logic                 beam_led_q, beam_led_d;
  logic                 flag_q, flag_d;
  logic [7:0]           flag_cnt_q, flag_cnt_d;
  phase_e               phase_q, phase_d;
  logic [7:0]           light_cnt_q, light_cnt_d;
  logic [mflc_pkg::SqW-1:0] sq_q, sq_d;
  logic [15:0]          servo_q, servo_d;
  logic [7:0]           duty_q, duty_d;

  logic [7:0]                     flag_cnt_inc;
  logic [7:0]                     light_cnt_inc;
  logic [mflc_pkg::SqW-1:0]       sq_inc;
  logic [mflc_pkg::RampXW-1:0]    ramp_x;
  logic [mflc_pkg::RampProdW-1:0] ramp_prod;
  logic [mflc_pkg::RampQW-1:0]    ramp_quo;
  logic [7:0]                     ramp_duty;

  // Advance when an item waits and the result register is free or emptying.
  assign take_o = item_valid_i & (~out_valid_q | ~out_stall_i);

  // Running square of the light count: (c+1)^2 = c^2 + 2c + 1.
  assign flag_cnt_inc  = flag_cnt_q + 8'd1;
  assign light_cnt_inc = light_cnt_q + 8'd1;
  assign sq_inc        = sq_q + mflc_pkg::SqW'({light_cnt_q, 1'b1});
  assign ramp_x        = sq_inc[mflc_pkg::SqW-1:mflc_pkg::RampPow2Sh];
  assign ramp_prod     = mflc_pkg::RampProdW'(ramp_x) *
                         mflc_pkg::RampProdW'(mflc_pkg::RecipMul);
  assign ramp_quo      = ramp_prod[mflc_pkg::RampProdW-1:mflc_pkg::RecipShift];
  assign ramp_duty     = (ramp_quo > mflc_pkg::RampQW'(mflc_pkg::FullDuty)) ?
                         mflc_pkg::FullDuty : ramp_quo[7:0];

  always_comb begin
    out_valid_d = out_valid_q;
    door_d      = door_q;
    beam_led_d  = beam_led_q;
    flag_d      = flag_q;
    flag_cnt_d  = flag_cnt_q;
    phase_d     = phase_q;
    light_cnt_d = light_cnt_q;
    sq_d        = sq_q;
    servo_d     = servo_q;
    duty_d      = duty_q;

    if (take_o) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (take_o) begin
      case (item_i.kind)
        mflc_pkg::KindDoor: begin
          if (!door_q && item_i.level) begin
            door_d      = 1'b1;
            duty_d      = 8'd0;
            light_cnt_d = 8'd0;
            sq_d        = '0;
            phase_d     = PhRamp;
          end else if (door_q && !item_i.level) begin
            door_d  = 1'b0;
            duty_d  = 8'd0;
            phase_d = PhOff;
          end
        end
        mflc_pkg::KindBeam: begin
          if (item_i.level) begin
            beam_led_d = 1'b0;
          end else begin
            beam_led_d = 1'b1;
            flag_cnt_d = 8'd0;
            if (!flag_q) begin
              servo_d = cfg_i.flag_up;
              flag_d  = 1'b1;
            end
          end
        end
        mflc_pkg::KindTick: begin
          if (flag_q) begin
            flag_cnt_d = flag_cnt_inc;
            if (flag_cnt_inc >= cfg_i.flag_hold) begin
              servo_d = cfg_i.flag_down;
              flag_d  = 1'b0;
            end
          end
          if (phase_q == PhRamp) begin
            light_cnt_d = light_cnt_inc;
            sq_d        = sq_inc;
            if (light_cnt_inc >= cfg_i.light_ramp) begin
              phase_d = PhOn;
              duty_d  = mflc_pkg::FullDuty;
            end else begin
              duty_d = ramp_duty;
            end
          end
        end
        default: ;  // unused kind: state unchanged
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      door_q      <= 1'b0;
      beam_led_q  <= 1'b0;
      flag_q      <= 1'b0;
      flag_cnt_q  <= 8'd0;
      phase_q     <= PhOff;
      light_cnt_q <= 8'd0;
      sq_q        <= '0;
      servo_q     <= mflc_pkg::FlagDownReset;
      duty_q      <= 8'd0;
    end else begin
      out_valid_q <= out_valid_d;
      door_q      <= door_d;
      beam_led_q  <= beam_led_d;
      flag_q      <= flag_d;
      flag_cnt_q  <= flag_cnt_d;
      phase_q     <= phase_d;
      light_cnt_q <= light_cnt_d;
      sq_q        <= sq_d;
      servo_q     <= servo_d;
      duty_q      <= duty_d;
    end
  end

  // Drive enable and door LED track the door state exactly.
  assign out_valid_o          = out_valid_q;
  assign servo_compare_o      = servo_q;
  assign light_duty_o         = duty_q;
  assign light_drive_enable_o = door_q;
  assign door_indicator_o     = door_q;
  assign beam_indicator_o     = beam_led_q;
  assign flag_is_up_o         = flag_q;
  assign door_is_open_o       = door_q;

`ifndef NO_ASSERTIONS
  a_sq_tracks_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_q == mflc_pkg::SqW'({8'd0, light_cnt_q} * {8'd0, light_cnt_q}))
    else $error("running square out of step with light count");

  a_door_vs_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    door_q == (phase_q != PhOff))
    else $error("light phase disagrees with door state");

  a_off_zero_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhOff) |-> (duty_q == 8'd0))
    else $error("nonzero duty with light off");

  a_raise_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_o && item_i.kind == mflc_pkg::KindBeam && !item_i.level && !flag_q)
    |=> (flag_q && servo_q == $past(cfg_i.flag_up)))
    else $error("beam break did not raise the flag");

  a_hold_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take_o |=> ($stable(servo_q) && $stable(duty_q) && $stable(flag_q)))
    else $error("state moved without an item");
`endif

endmodule

`default_nettype wire

[hdl/mailbox_flag_and_light_controller.sv]
// Top level of the mailbox flag and light controller.
//
//   channel  direction  handshake                 payload
//   -------  ---------  ------------------------  ------------------------------------
//   in       sink       in_valid_i / in_stall_o    kind_i, level_i
//   out      source     out_valid_o / out_stall_i  servo_compare_o, light_duty_o,
//                                                  light_drive_enable_o, door_indicator_o,
//                                                  beam_indicator_o, flag_is_up_o,
//                                                  door_is_open_o
//   cfg      sink       cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One item per cycle sustained while out_stall_i is low; an accepted item
// passes the input register, then the state/result register, before its
// result is presented on the out channel.
// The whole event update is one pass of short logic; the light ramp divide by
// 88 is a shift plus one 13x12 reciprocal multiply on a running square.
// Reset clears all state, loads register defaults and parks the servo at the
// down compare value. Configuration is always ready.
// An output stall holds the result register and all state; the input register
// then fills and raises in_stall_o.
`default_nettype none

module mailbox_flag_and_light_controller (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  // event items
  input  wire                           in_valid_i,
  output logic                          in_stall_o,
  input  wire [1:0]                     kind_i,
  input  wire                           level_i,
  // result items
  output logic                          out_valid_o,
  input  wire                           out_stall_i,
  output logic [15:0]                   servo_compare_o,
  output logic [7:0]                    light_duty_o,
  output logic                          light_drive_enable_o,
  output logic                          door_indicator_o,
  output logic                          beam_indicator_o,
  output logic                          flag_is_up_o,
  output logic                          door_is_open_o,
  // register writes
  input  wire                           cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire [mflc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire [mflc_pkg::CfgDataW-1:0]  cfg_data_i
);

  mflc_pkg::cfg_t  cfg;
  mflc_pkg::item_t item;
  logic            item_valid;
  logic            take;

  // Register file: flag compares, hold and ramp lengths.
  mflc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Capture the incoming event; hold it while the result side is blocked.
  mflc_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .level_i      (level_i),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  // Apply the event to door, beam, flag and light state; the state registers
  // double as the result register.
  mflc_core u_core (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_i                (cfg),
    .item_valid_i         (item_valid),
    .item_i               (item),
    .take_o               (take),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .servo_compare_o      (servo_compare_o),
    .light_duty_o         (light_duty_o),
    .light_drive_enable_o (light_drive_enable_o),
    .door_indicator_o     (door_indicator_o),
    .beam_indicator_o     (beam_indicator_o),
    .flag_is_up_o         (flag_is_up_o),
    .door_is_open_o       (door_is_open_o)
  );

endmodule

`default_nettype wire

[dv/mailbox_flag_and_light_controller_tb.sv]
// Self-checking testbench for the mailbox flag and light controller.
`timescale 1ns / 1ps

module mailbox_flag_and_light_controller_tb;
  import mflc_pkg::*;

  // Timing of the bench. An accepted item passes the input register and then
  // the result register, so a short drain after the last result is enough.
  localparam int ResetCycles = 6;
  localparam int DrainCycles = 4;
  localparam int TailCycles  = 8;
  localparam int HoldOffLen  = 64;
  localparam int MaxReports  = 10;
  localparam int ScriptLen   = 36;
  localparam int Phases      = 6;
  localparam longint TimeoutNs = 64'd3_000_000;

  // Event kind that the block ignores, and a register index past the map.
  localparam logic [1:0]         KindUnused  = 2'd3;
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 4'd15;

  typedef enum logic [1:0] {
    LightOff  = 2'd0,
    LightOn   = 2'd1,
    LightRamp = 2'd2
  } light_phase_e;

  // What one result item shows: servo, duty, enables and LEDs.
  typedef struct packed {
    logic [15:0] servo;
    logic [7:0]  duty;
    logic        drive_en;
    logic        door_led;
    logic        beam_led;
    logic        flag_up;
    logic        door_open;
  } panel_t;

  // Tracked mailbox state, as the block should hold it.
  typedef struct packed {
    logic         door_open;
    logic         beam_seen;
    logic         flag_up;
    logic [7:0]   flag_ticks;
    light_phase_e phase;
    logic [7:0]   ramp_ticks;
    logic [15:0]  servo;
    logic [7:0]   duty;
    logic         drive_en;
    logic         door_led;
    logic         beam_led;
  } mbox_state_t;

  // One row of the directed sequence: either a register write or an event,
  // optionally with its result written out by hand.
  typedef struct packed {
    logic               is_write;
    logic [CfgIdxW-1:0] idx;
    logic [15:0]        data;
    logic [1:0]         kind;
    logic               level;
    logic               known;
    panel_t             want;
  } step_row_t;

  logic clk;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  ev_kind  = 2'd0;
  logic        ev_level = 1'b0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] servo_compare;
  logic [7:0]  light_duty;
  logic        light_drive_enable;
  logic        door_indicator;
  logic        beam_indicator;
  logic        flag_is_up;
  logic        door_is_open;

  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  // Hand-written result for the item on offer; moves with the payload.
  logic   known_use  = 1'b0;
  panel_t known_want = '0;

  // Predictor state and the results still owed by the block.
  cfg_t        regs;
  mbox_state_t mbox;
  panel_t      panel_q[$];

  // Knobs shared by the stimulus and the receiver.
  bit sender_calm   = 1'b0;
  bit hold_off_req  = 1'b0;

  int unsigned items_in, results_out, reg_writes, hold_offs;
  int unsigned door_items, beam_items, tick_items, spare_items;
  int unsigned flag_drops, ramps_done, sat_steps;
  int unsigned mismatches, strays;

  step_row_t script [ScriptLen];

  mailbox_flag_and_light_controller i_dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .kind_i              (ev_kind),
    .level_i             (ev_level),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .servo_compare_o     (servo_compare),
    .light_duty_o        (light_duty),
    .light_drive_enable_o(light_drive_enable),
    .door_indicator_o    (door_indicator),
    .beam_indicator_o    (beam_indicator),
    .flag_is_up_o        (flag_is_up),
    .door_is_open_o      (door_is_open),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Give up on a hung run.
  initial begin
    #(TimeoutNs);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Advance the tracked mailbox by one event and return what it should show.
  function automatic panel_t advance_mailbox(input logic [1:0] kind, input logic level);
    int unsigned sq;
    case (kind)
      KindDoor: begin
        // Only a level change moves the door; opening restarts the ramp at zero.
        if (!mbox.door_open && level) begin
          mbox.door_open  = 1'b1;
          mbox.door_led   = 1'b1;
          mbox.duty       = '0;
          mbox.drive_en   = 1'b1;
          mbox.ramp_ticks = '0;
          mbox.phase      = LightRamp;
        end else if (mbox.door_open && !level) begin
          mbox.door_open = 1'b0;
          mbox.door_led  = 1'b0;
          mbox.duty      = '0;
          mbox.drive_en  = 1'b0;
          mbox.phase     = LightOff;
        end
      end
      KindBeam: begin
        if (level) begin
          mbox.beam_seen = 1'b1;
          mbox.beam_led  = 1'b0;
        end else begin
          // Broken beam restarts the hold; raise the flag only if it is down.
          mbox.beam_seen  = 1'b0;
          mbox.beam_led   = 1'b1;
          mbox.flag_ticks = '0;
          if (!mbox.flag_up) begin
            mbox.servo   = regs.flag_up;
            mbox.flag_up = 1'b1;
          end
        end
      end
      KindTick: begin
        if (mbox.flag_up) begin
          mbox.flag_ticks = mbox.flag_ticks + 8'd1;
          if (mbox.flag_ticks >= regs.flag_hold) begin
            mbox.servo   = regs.flag_down;
            mbox.flag_up = 1'b0;
            flag_drops++;
          end
        end
        if (mbox.phase == LightRamp) begin
          mbox.ramp_ticks = mbox.ramp_ticks + 8'd1;
          if (mbox.ramp_ticks >= regs.light_ramp) begin
            mbox.phase = LightOn;
            mbox.duty  = FullDuty;
            ramps_done++;
          end else begin
            // Quadratic ramp; long ramps overshoot the duty range and clip.
            sq = (int'(mbox.ramp_ticks) * int'(mbox.ramp_ticks)) / RampDivisor;
            if (sq > FullDuty) begin
              mbox.duty = FullDuty;
              sat_steps++;
            end else begin
              mbox.duty = sq[7:0];
            end
          end
        end
      end
      default: ;
    endcase
    return panel_t'{mbox.servo, mbox.duty, mbox.drive_en, mbox.door_led,
                    mbox.beam_led, mbox.flag_up, mbox.door_open};
  endfunction

  function automatic step_row_t row_event(input logic [1:0] kind, input logic level);
    return step_row_t'{1'b0, '0, '0, kind, level, 1'b0, '0};
  endfunction

  function automatic step_row_t row_known(input logic [1:0] kind, input logic level,
                                          input panel_t want);
    return step_row_t'{1'b0, '0, '0, kind, level, 1'b1, want};
  endfunction

  function automatic step_row_t row_write(input logic [CfgIdxW-1:0] idx,
                                          input logic [15:0] data);
    return step_row_t'{1'b1, idx, data, 2'd0, 1'b0, 1'b0, '0};
  endfunction

  // Mostly short sender gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // Offer one item and hold it until the block takes it. Valid stays high
  // after acceptance so that back-to-back items need no extra edge.
  task automatic send_event(input logic [1:0] kind, input logic level,
                            input logic known, input panel_t want);
    int gap;
    gap = sender_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    ev_kind    <= kind;
    ev_level   <= level;
    known_use  <= known;
    known_want <= want;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait until every owed result has come back.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (panel_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Scoreboard: track register writes, predict each accepted item, and check
  // each accepted result against the oldest prediction.
  always @(posedge clk) begin : scoreboard
    panel_t want;
    panel_t got;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        reg_writes++;
        case (cfg_index)
          CfgFlagUp:    regs.flag_up    = cfg_data;
          CfgFlagDown:  regs.flag_down  = cfg_data;
          CfgFlagHold:  regs.flag_hold  = cfg_data[7:0];
          CfgLightRamp: regs.light_ramp = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        items_in++;
        case (ev_kind)
          KindDoor: door_items++;
          KindBeam: beam_items++;
          KindTick: tick_items++;
          default:  spare_items++;
        endcase
        want = advance_mailbox(ev_kind, ev_level);
        // Hand-written rows override the prediction; the state still advances.
        if (known_use) want = known_want;
        panel_q.push_back(want);
      end
      if (out_valid && !out_stall) begin
        results_out++;
        got = panel_t'{servo_compare, light_duty, light_drive_enable, door_indicator,
                       beam_indicator, flag_is_up, door_is_open};
        if (panel_q.size() == 0) begin
          strays++;
          if (mismatches + strays <= MaxReports)
            $display("%0t: result with nothing owed: servo=%0d duty=%0d", $realtime,
                     got.servo, got.duty);
        end else begin
          want = panel_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches + strays <= MaxReports) begin
              $display("%0t: result %0d differs", $realtime, results_out);
              $display("  expected servo=%0d duty=%0d en=%b door_led=%b beam_led=%b flag=%b door=%b",
                       want.servo, want.duty, want.drive_en, want.door_led,
                       want.beam_led, want.flag_up, want.door_open);
              $display("  actual   servo=%0d duty=%0d en=%b door_led=%b beam_led=%b flag=%b door=%b",
                       got.servo, got.duty, got.drive_en, got.door_led,
                       got.beam_led, got.flag_up, got.door_open);
            end
          end
        end
      end
    end
  end

  // Receiver: random stalls, mostly short, with stalling-free stretches and
  // the occasional long one. On request, hold off for a fixed long stretch so
  // the block fills up and stalls its input.
  initial begin : receiver
    int r;
    int len;
    bit stall_v;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HoldOffLen) @(posedge clk);
        hold_off_req = 1'b0;
        hold_offs++;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          stall_v = 1'b0;
          len     = $urandom_range(1, 30);
        end else if (r < 92) begin
          stall_v = 1'b1;
          len     = $urandom_range(1, 3);
        end else begin
          stall_v = 1'b1;
          len     = $urandom_range(10, 40);
        end
        out_stall <= stall_v;
        repeat (len) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [15:0] up_v, down_v;
    logic [7:0]  hold_v, ramp_v;
    int n_items, door_pct, beam_pct, open_pct, r;
    logic [1:0] kind;
    logic level;

    // Reset values of registers and state.
    regs = cfg_t'{FlagUpReset, FlagDownReset, FlagHoldReset, LightRampReset};
    mbox = '0;
    mbox.phase = LightOff;
    mbox.servo = FlagDownReset;

    // Directed part. Rows with a written-out result sit where the answer is
    // plain: right after reset, at register extremes and at zero lengths.
    script = '{
      row_known(KindUnused, 1'b0, panel_t'{16'd1350, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}),
      row_known(KindTick,   1'b0, panel_t'{16'd1350, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}),
      row_known(KindDoor,   1'b0, panel_t'{16'd1350, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}),
      row_known(KindBeam,   1'b1, panel_t'{16'd1350, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}),
      row_known(KindBeam,   1'b0, panel_t'{16'd670,  8'd0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}),
      row_known(KindBeam,   1'b0, panel_t'{16'd670,  8'd0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}),
      row_known(KindDoor,   1'b1, panel_t'{16'd670,  8'd0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}),
      row_known(KindDoor,   1'b1, panel_t'{16'd670,  8'd0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}),
      row_known(KindTick,   1'b0, panel_t'{16'd670,  8'd0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}),
      row_event(KindTick,   1'b1),
      row_event(KindUnused, 1'b1),
      row_event(KindBeam,   1'b1),
      row_known(KindDoor,   1'b0, panel_t'{16'd670,  8'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0}),
      row_event(KindTick,   1'b0),
      // Shortest hold and ramp, compare values at their extremes.
      row_write(CfgFlagHold,  16'd1),
      row_write(CfgLightRamp, 16'd1),
      row_write(CfgFlagUp,    16'hFFFF),
      row_write(CfgFlagDown,  16'h0000),
      row_known(KindTick,   1'b0, panel_t'{16'd0,     8'd0,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0}),
      row_known(KindBeam,   1'b0, panel_t'{16'd65535, 8'd0,   1'b0, 1'b0, 1'b1, 1'b1, 1'b0}),
      row_known(KindDoor,   1'b1, panel_t'{16'd65535, 8'd0,   1'b1, 1'b1, 1'b1, 1'b1, 1'b1}),
      row_known(KindTick,   1'b0, panel_t'{16'd0,     8'd255, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1}),
      // Zero lengths via upper data bits that the 8-bit registers drop,
      // plus a write past the register map that must change nothing.
      row_write(CfgFlagHold,  16'hFF00),
      row_write(CfgLightRamp, 16'h0100),
      row_write(CfgIdxSpare,  16'hFFFF),
      row_event(KindDoor,   1'b0),
      row_event(KindBeam,   1'b0),
      row_event(KindDoor,   1'b1),
      row_known(KindTick,   1'b1, panel_t'{16'd0,     8'd255, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1}),
      // Longest hold and ramp.
      row_write(CfgFlagHold,  16'd255),
      row_write(CfgLightRamp, 16'd255),
      row_write(CfgFlagUp,    16'h0000),
      row_write(CfgFlagDown,  16'hFFFF),
      row_event(KindBeam,   1'b0),
      row_event(KindTick,   1'b1),
      row_event(KindTick,   1'b0)
    };

    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < ScriptLen; i++) begin
      if (script[i].is_write) begin
        settle();
        write_reg(script[i].idx, script[i].data);
      end else begin
        send_event(script[i].kind, script[i].level, script[i].known, script[i].want);
      end
    end

    // Random part: each phase loads a register set, then streams events.
    // Door and beam rates are kept low where hold and ramp are long, so that
    // runs of ticks reach the flag drop and the clipped end of the ramp.
    for (int p = 0; p < Phases; p++) begin
      case (p)
        0: begin
          up_v = FlagUpReset; down_v = FlagDownReset;
          hold_v = FlagHoldReset; ramp_v = LightRampReset;
          n_items = 300; door_pct = 3; beam_pct = 3; open_pct = 70;
        end
        1: begin
          up_v = 16'hFFFF; down_v = 16'h0000; hold_v = 8'd255; ramp_v = 8'd255;
          n_items = 300; door_pct = 2; beam_pct = 2; open_pct = 90;
        end
        2: begin
          up_v = 16'h0000; down_v = 16'hFFFF; hold_v = 8'd1; ramp_v = 8'd1;
          n_items = 200; door_pct = 20; beam_pct = 20; open_pct = 50;
        end
        default: begin
          up_v = 16'($urandom); down_v = 16'($urandom);
          hold_v = 8'($urandom_range(0, 255)); ramp_v = 8'($urandom_range(0, 255));
          n_items = 200; door_pct = 10; beam_pct = 10; open_pct = 60;
        end
      endcase
      settle();
      // Random upper bits on the 8-bit registers must be dropped.
      write_reg(CfgFlagUp, up_v);
      write_reg(CfgFlagDown, down_v);
      write_reg(CfgFlagHold, {8'($urandom), hold_v});
      write_reg(CfgLightRamp, {8'($urandom), ramp_v});
      write_reg(CfgIdxW'($urandom_range(int'(CfgLightRamp) + 1, (1 << CfgIdxW) - 1)),
                16'($urandom));

      for (int i = 0; i < n_items; i++) begin
        // Back up the output early in the run while items keep coming.
        if (p == 0 && i == 30) hold_off_req = 1'b1;
        sender_calm = (p == 0 && i >= 30 && i < 70) || (i % 100 >= 80);
        r = $urandom_range(0, 99);
        if (r < door_pct) begin
          kind  = KindDoor;
          level = ($urandom_range(0, 99) < open_pct);
        end else if (r < door_pct + beam_pct) begin
          kind  = KindBeam;
          level = 1'($urandom);
        end else if (r < door_pct + beam_pct + 4) begin
          kind  = KindUnused;
          level = 1'($urandom);
        end else begin
          kind  = KindTick;
          level = 1'($urandom);
        end
        send_event(kind, level, 1'b0, '0);
      end
      sender_calm = 1'b0;
    end

    settle();
    repeat (TailCycles) @(posedge clk);

    $display("Covered %0d items (door %0d, beam %0d, tick %0d, unused kind %0d), %0d results.",
             items_in, door_items, beam_items, tick_items, spare_items, results_out);
    $display("Writes %0d, flag drops %0d, ramps done %0d, clipped ramp steps %0d, long hold-offs %0d.",
             reg_writes, flag_drops, ramps_done, sat_steps, hold_offs);
    if (panel_q.size() != 0)
      $display("%0d results never arrived", panel_q.size());
    if (mismatches == 0 && strays == 0 && panel_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d unexpected results", mismatches, strays);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
